// File: hw/rtl/blm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blm_pkg
// Types and constants shared by the battery limit monitor.
// ----------------------------------------------------------------------------
package blm_pkg;

  // operating mode codes
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_DRIVE    = 3'd1;
  localparam logic [2:0] MODE_CHG_SUP  = 3'd2;
  localparam logic [2:0] MODE_CHG_MAIN = 3'd3;
  localparam logic [2:0] MODE_CHG_SYM  = 3'd4;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_VOLT_LOW      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DRV_VOLT_HIGH = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CHG_VOLT_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CHG_CUR       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DSG_CUR       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CHG_TEMP_HIGH = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DRV_TEMP_HIGH = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_FULL_CAP      = 3'd7;

  localparam int unsigned CfgDataW = 16;

  // register reset values
  localparam logic [15:0]        VOLT_LOW_RST      = 16'd31000;
  localparam logic [15:0]        DRV_VOLT_HIGH_RST = 16'd40000;
  localparam logic [15:0]        CHG_VOLT_HIGH_RST = 16'd43500;
  localparam logic signed [15:0] CHG_CUR_RST       = 16'sd280;
  localparam logic signed [15:0] DSG_CUR_RST       = -16'sd1500;
  localparam logic signed [15:0] CHG_TEMP_HIGH_RST = 16'sd4500;
  localparam logic signed [15:0] DRV_TEMP_HIGH_RST = 16'sd5500;
  localparam logic signed [15:0] FULL_CAP_RST      = 16'sd400;

  // fixed limits
  localparam logic signed [15:0] SYM_CUR_LIMIT     = 16'sd28;
  localparam logic signed [15:0] CHG_TEMP_LOW      = 16'sd0;
  localparam logic signed [15:0] DRV_TEMP_LOW      = -16'sd2000;
  localparam logic signed [16:0] TEMP_RISE_LIMIT   = 17'sd100;
  localparam logic [31:0]        CHECK_INTERVAL_MS = 32'd120000;
  localparam logic signed [15:0] LAST_TEMP_RST     = 16'sd4500;

  typedef struct packed {
    logic [15:0]        voltage_low_limit;
    logic [15:0]        drive_voltage_high_limit;
    logic [15:0]        charge_voltage_high_limit;
    logic signed [15:0] charge_current_limit;
    logic signed [15:0] discharge_current_limit;
    logic signed [15:0] charge_temp_high_limit;
    logic signed [15:0] drive_temp_high_limit;
    logic signed [15:0] full_capacity_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [15:0]        voltage;
    logic signed [15:0] current;
    logic signed [15:0] min_temp;
    logic signed [15:0] max_temp;
    logic signed [15:0] avg_temp;
    logic signed [15:0] capacity;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic volt_low_flag;
    logic volt_high_flag;
    logic charge_cur_high_flag;
    logic drive_cur_high_flag;
    logic charge_temp_high_flag;
    logic charge_temp_low_flag;
    logic drive_temp_high_flag;
    logic drive_temp_low_flag;
    logic full_flag;
  } out_item_t;

endpackage

// File: hw/rtl/blm_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blm_cfg_regs
// Limit register file, written through a plain write port.
// ----------------------------------------------------------------------------
module blm_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [blm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [blm_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output blm_pkg::cfg_t                    cfg_o
);

  blm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        blm_pkg::REG_VOLT_LOW:      cfg_d.voltage_low_limit         = cfg_wdata_i;
        blm_pkg::REG_DRV_VOLT_HIGH: cfg_d.drive_voltage_high_limit  = cfg_wdata_i;
        blm_pkg::REG_CHG_VOLT_HIGH: cfg_d.charge_voltage_high_limit = cfg_wdata_i;
        blm_pkg::REG_CHG_CUR:       cfg_d.charge_current_limit      = cfg_wdata_i;
        blm_pkg::REG_DSG_CUR:       cfg_d.discharge_current_limit   = cfg_wdata_i;
        blm_pkg::REG_CHG_TEMP_HIGH: cfg_d.charge_temp_high_limit    = cfg_wdata_i;
        blm_pkg::REG_DRV_TEMP_HIGH: cfg_d.drive_temp_high_limit     = cfg_wdata_i;
        blm_pkg::REG_FULL_CAP:      cfg_d.full_capacity_limit       = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.voltage_low_limit         <= blm_pkg::VOLT_LOW_RST;
      cfg_q.drive_voltage_high_limit  <= blm_pkg::DRV_VOLT_HIGH_RST;
      cfg_q.charge_voltage_high_limit <= blm_pkg::CHG_VOLT_HIGH_RST;
      cfg_q.charge_current_limit      <= blm_pkg::CHG_CUR_RST;
      cfg_q.discharge_current_limit   <= blm_pkg::DSG_CUR_RST;
      cfg_q.charge_temp_high_limit    <= blm_pkg::CHG_TEMP_HIGH_RST;
      cfg_q.drive_temp_high_limit     <= blm_pkg::DRV_TEMP_HIGH_RST;
      cfg_q.full_capacity_limit       <= blm_pkg::FULL_CAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/blm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blm_core
// Limit checks and sticky flag state. The flag register doubles as the
// result register.
// ----------------------------------------------------------------------------
module blm_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  blm_pkg::in_item_t  item_i,
  input  blm_pkg::cfg_t      cfg_i,
  output blm_pkg::out_item_t flags_o
);

  blm_pkg::out_item_t  flags_q, flags_d;
  logic signed [15:0]  last_temp_q, last_temp_d;
  logic [31:0]         last_time_q, last_time_d;

  logic [15:0]         volt_high_lim;
  logic [31:0]         elapsed;
  logic signed [16:0]  temp_rise;
  logic                v_low, v_high, c_chg, c_dsg;

  always_comb begin
    volt_high_lim = (item_i.mode == blm_pkg::MODE_DRIVE) ?
                    cfg_i.drive_voltage_high_limit : cfg_i.charge_voltage_high_limit;
    v_low  = item_i.voltage < cfg_i.voltage_low_limit;
    v_high = !v_low && (item_i.voltage >= volt_high_lim);
    c_chg  = $signed(item_i.current) > $signed(cfg_i.charge_current_limit);
    c_dsg  = !c_chg && !($signed(item_i.current) > $signed(cfg_i.discharge_current_limit));
    elapsed   = item_i.now_ms - last_time_q;
    temp_rise = {item_i.avg_temp[15], item_i.avg_temp} - {last_temp_q[15], last_temp_q};
  end

  always_comb begin
    flags_d     = flags_q;
    last_temp_d = last_temp_q;
    last_time_d = last_time_q;
    unique case (item_i.mode) inside
      blm_pkg::MODE_DRIVE: begin
        flags_d.drive_temp_low_flag  = $signed(item_i.min_temp) < blm_pkg::DRV_TEMP_LOW;
        flags_d.drive_temp_high_flag =
          $signed(item_i.max_temp) >= $signed(cfg_i.drive_temp_high_limit);
        flags_d.volt_low_flag        = v_low;
        flags_d.volt_high_flag       = v_high;
        flags_d.charge_cur_high_flag = c_chg;
        flags_d.drive_cur_high_flag  = c_dsg;
        flags_d.full_flag            = 1'b0;
      end
      blm_pkg::MODE_CHG_SUP, blm_pkg::MODE_CHG_MAIN: begin
        flags_d.charge_temp_low_flag  = $signed(item_i.min_temp) < blm_pkg::CHG_TEMP_LOW;
        flags_d.charge_temp_high_flag =
          $signed(item_i.max_temp) >= $signed(cfg_i.charge_temp_high_limit);
        flags_d.volt_low_flag         = v_low;
        flags_d.volt_high_flag        = v_high;
        flags_d.charge_cur_high_flag  = c_chg;
        flags_d.drive_cur_high_flag   = c_dsg;
        if (item_i.mode == blm_pkg::MODE_CHG_MAIN) begin
          if (elapsed >= blm_pkg::CHECK_INTERVAL_MS) begin
            last_time_d = item_i.now_ms;
            last_temp_d = item_i.avg_temp;
            if (temp_rise > blm_pkg::TEMP_RISE_LIMIT) begin
              flags_d.full_flag = 1'b1;
            end
          end
          if ($signed(item_i.capacity) > $signed(cfg_i.full_capacity_limit)) begin
            flags_d.full_flag = 1'b1;
          end
        end
      end
      blm_pkg::MODE_CHG_SYM: begin
        flags_d.charge_cur_high_flag = $signed(item_i.current) > blm_pkg::SYM_CUR_LIMIT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      last_temp_q <= blm_pkg::LAST_TEMP_RST;
      last_time_q <= '0;
    end else if (step_i) begin
      flags_q     <= flags_d;
      last_temp_q <= last_temp_d;
      last_time_q <= last_time_d;
    end
  end

  assign flags_o = flags_q;

endmodule

// File: hw/rtl/battery_limit_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_limit_monitor_top
// Battery limit monitor: sticky limit flags from monitoring samples.
// ----------------------------------------------------------------------------
// One sample per cycle sustained while out_ready_i is high. A sample is registered
// in the input register on acceptance, checked against the limits from there
// and its nine flags are then loaded into the flag register, which is the
// result register. The input register takes a new sample while a result
// waits, as long as the held sample can move on.
// ----------------------------------------------------------------------------
module battery_limit_monitor_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  blm_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output blm_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [blm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [blm_pkg::CfgDataW-1:0] cfg_wdata_i
);

  blm_pkg::cfg_t     cfg;
  blm_pkg::in_item_t in_q;
  logic              in_valid_q, in_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              advance, in_fire;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_valid_d  = in_fire || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
  end

  blm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  blm_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_q),
    .cfg_i   (cfg),
    .flags_o (out_data_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

// File: bench/battery_limit_monitor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_limit_monitor_top_tb
// Self-checking bench for the battery limit monitor. A driver feeds samples
// from a queue with random gaps, a monitor takes flag results under random
// stalls and compares each flag against a predictor of the sticky flags,
// the main-charge full judgment and the interval temperature check. The run
// goes through default, minimum, maximum and random limit settings.
// ----------------------------------------------------------------------------
module battery_limit_monitor_top_tb;
  import blm_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  battery_limit_monitor_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  localparam cfg_t LIMITS_DEFAULT = '{VOLT_LOW_RST, DRV_VOLT_HIGH_RST, CHG_VOLT_HIGH_RST,
                                      CHG_CUR_RST, DSG_CUR_RST, CHG_TEMP_HIGH_RST,
                                      DRV_TEMP_HIGH_RST, FULL_CAP_RST};
  localparam cfg_t LIMITS_MIN = '{16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000,
                                  16'h8000, 16'h8000, 16'h8000};
  localparam cfg_t LIMITS_MAX = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF,
                                  16'h7FFF, 16'h7FFF, 16'h7FFF};

  // bit order of out_item_t, index 0 is the LSB
  string flag_names [9] = '{"full_flag", "drive_temp_low_flag", "drive_temp_high_flag",
                            "charge_temp_low_flag", "charge_temp_high_flag",
                            "drive_cur_high_flag", "charge_cur_high_flag",
                            "volt_high_flag", "volt_low_flag"};

  // predictor state
  cfg_t               limits = LIMITS_DEFAULT;
  out_item_t          flag_state = '0;
  logic signed [15:0] last_check_avg = LAST_TEMP_RST;
  logic [31:0]        last_check_ms = '0;

  in_item_t  sample_queue [$];
  out_item_t flags_due [$];
  out_item_t want;

  int send_gap = 0, send_burst = 0, recv_stall = 0, recv_burst = 0;
  int mismatches = 0, results_seen = 0, full_seen = 0, settings_used = 1;
  int mode_hits [8] = '{default: 0};
  int gen_avg = 4500;
  logic [31:0] gen_ms = '0;

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic out_item_t update_limit_flags(input in_item_t s);
    logic [15:0] vhigh;
    int          rise;
    if (s.mode == MODE_DRIVE || s.mode == MODE_CHG_SUP || s.mode == MODE_CHG_MAIN) begin
      if (s.mode == MODE_DRIVE) begin
        flag_state.drive_temp_low_flag  = $signed(s.min_temp) < DRV_TEMP_LOW;
        flag_state.drive_temp_high_flag =
          $signed(s.max_temp) >= $signed(limits.drive_temp_high_limit);
        vhigh = limits.drive_voltage_high_limit;
      end else begin
        flag_state.charge_temp_low_flag  = $signed(s.min_temp) < CHG_TEMP_LOW;
        flag_state.charge_temp_high_flag =
          $signed(s.max_temp) >= $signed(limits.charge_temp_high_limit);
        vhigh = limits.charge_voltage_high_limit;
      end
      flag_state.volt_low_flag  = s.voltage < limits.voltage_low_limit;
      flag_state.volt_high_flag = !(s.voltage < limits.voltage_low_limit) && !(s.voltage < vhigh);
      flag_state.charge_cur_high_flag =
        $signed(s.current) > $signed(limits.charge_current_limit);
      flag_state.drive_cur_high_flag = !flag_state.charge_cur_high_flag &&
        !($signed(s.current) > $signed(limits.discharge_current_limit));
      if (s.mode == MODE_DRIVE) flag_state.full_flag = 1'b0;
      if (s.mode == MODE_CHG_MAIN) begin
        if (32'(s.now_ms - last_check_ms) >= CHECK_INTERVAL_MS) begin
          last_check_ms = s.now_ms;
          rise = int'($signed(s.avg_temp)) - int'(last_check_avg);
          if (rise > int'(TEMP_RISE_LIMIT)) flag_state.full_flag = 1'b1;
          last_check_avg = s.avg_temp;
        end
        if ($signed(s.capacity) > $signed(limits.full_capacity_limit))
          flag_state.full_flag = 1'b1;
      end
    end else if (s.mode == MODE_CHG_SYM) begin
      flag_state.charge_cur_high_flag = $signed(s.current) > SYM_CUR_LIMIT;
    end
    return flag_state;
  endfunction

  // mostly short gaps, some long, and now and then a stretch of none
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_near(input logic [15:0] a, input logic [15:0] b);
    int r, ofs;
    r   = $urandom_range(0, 11);
    ofs = int'($urandom_range(0, 6)) - 3;
    if (r < 3) return 16'($urandom);
    if (r < 7) return a + 16'(ofs);
    if (r < 10) return b + 16'(ofs);
    if (r == 11) return a;
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      default: return 16'h8000;
    endcase
  endfunction

  function automatic in_item_t sample(input logic [2:0] m, input int v, input int c,
                                      input int tmin, input int tmax, input int tavg,
                                      input int cap, input logic [31:0] t);
    in_item_t s;
    s.mode     = m;
    s.voltage  = 16'(v);
    s.current  = 16'(c);
    s.min_temp = 16'(tmin);
    s.max_temp = 16'(tmax);
    s.avg_temp = 16'(tavg);
    s.capacity = 16'(cap);
    s.now_ms   = t;
    return s;
  endfunction

  function automatic in_item_t shaped_sample(input logic [2:0] m);
    in_item_t s;
    int       r;
    s.mode     = m;
    s.voltage  = pick_near(limits.voltage_low_limit, $urandom_range(0, 1) ?
                           limits.drive_voltage_high_limit : limits.charge_voltage_high_limit);
    s.current  = pick_near(m == MODE_CHG_SYM ? SYM_CUR_LIMIT : limits.charge_current_limit,
                           limits.discharge_current_limit);
    s.min_temp = pick_near(CHG_TEMP_LOW, DRV_TEMP_LOW);
    s.max_temp = pick_near(limits.charge_temp_high_limit, limits.drive_temp_high_limit);
    gen_avg += int'($urandom_range(0, 120)) - 40;
    if (gen_avg > 30000 || gen_avg < -30000) gen_avg = int'($urandom_range(0, 6000)) - 1000;
    s.avg_temp = ($urandom_range(0, 9) == 0) ? pick_near(16'(gen_avg), LAST_TEMP_RST)
                                             : 16'(gen_avg);
    s.capacity = pick_near(limits.full_capacity_limit, 16'h0000);
    r = $urandom_range(0, 99);
    if (r < 55)      gen_ms += $urandom_range(0, 60000);
    else if (r < 80) gen_ms += $urandom_range(100000, 140000);
    else if (r < 90) gen_ms += CHECK_INTERVAL_MS - 1 + $urandom_range(0, 2);
    else if (r < 95) gen_ms = $urandom;
    s.now_ms = gen_ms;
    return s;
  endfunction

  function automatic logic [2:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return MODE_DRIVE;
    if (r < 45) return MODE_CHG_SUP;
    if (r < 75) return MODE_CHG_MAIN;
    if (r < 85) return MODE_CHG_SYM;
    r = $urandom_range(0, 3);
    return (r == 0) ? MODE_IDLE : MODE_CHG_SYM + 3'(r);
  endfunction

  task automatic queue_random(input int n);
    logic [159:0] raw;
    logic [2:0]   m;
    int           left;
    left   = 0;
    m      = MODE_IDLE;
    gen_ms = $urandom;
    repeat (n) begin
      if (left == 0) begin
        m    = pick_mode();
        left = $urandom_range(5, 40);
      end
      left--;
      if ($urandom_range(0, 9) == 0) begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        sample_queue.push_back(in_item_t'(raw[$bits(in_item_t)-1:0]));
      end else begin
        sample_queue.push_back(shaped_sample(m));
      end
    end
  endtask

  task automatic queue_directed();
    sample_queue.push_back(sample(MODE_IDLE, 0, 0, 0, 0, 0, 0, 32'd0));
    sample_queue.push_back(sample(MODE_DRIVE, 0, -32768, -32768, 32767, 0, 0, 32'd0));
    sample_queue.push_back(sample(MODE_DRIVE, 65535, 32767, -2000, 5499, 0, 0, 32'd0));
    sample_queue.push_back(sample(MODE_DRIVE, 40000, -1500, -2001, 5500, 0, 0, 32'd0));
    sample_queue.push_back(sample(MODE_DRIVE, 39999, -1499, 32767, -32768, 0, 0, 32'd0));
    sample_queue.push_back(sample(MODE_DRIVE, 30999, 281, 2000, 2000, 0, 0, 32'd0));
    sample_queue.push_back(sample(MODE_DRIVE, 31000, 280, 2000, 2000, 0, 0, 32'd0));
    sample_queue.push_back(sample(MODE_CHG_SUP, 43499, 281, -1, 4500, 0, 0, 32'd0));
    sample_queue.push_back(sample(MODE_CHG_SUP, 43500, -1501, 0, 4499, 0, 0, 32'd0));
    // interval not yet elapsed, then exactly elapsed with a rise just over the limit
    sample_queue.push_back(sample(MODE_CHG_MAIN, 35000, 0, 2000, 2000, 32767, 400, 32'd119999));
    sample_queue.push_back(sample(MODE_CHG_MAIN, 35000, 0, 2000, 2000, 4601, 400, 32'd120000));
    sample_queue.push_back(sample(MODE_DRIVE, 35000, 0, 2000, 2000, 0, 0, 32'd0));
    sample_queue.push_back(sample(MODE_CHG_MAIN, 35000, 0, 2000, 2000, 4701, 401, 32'd240000));
    sample_queue.push_back(sample(MODE_DRIVE, 35000, 0, 2000, 2000, 0, 0, 32'd0));
    // rise across the full 16-bit span must not wrap
    sample_queue.push_back(sample(MODE_CHG_MAIN, 35000, 0, 2000, 2000, -32768, -32768,
                                  32'd360000));
    sample_queue.push_back(sample(MODE_CHG_MAIN, 35000, 0, 2000, 2000, 32767, -32768,
                                  32'd480000));
    sample_queue.push_back(sample(MODE_DRIVE, 35000, 0, 2000, 2000, 0, 0, 32'd0));
    // time stamp wrap
    sample_queue.push_back(sample(MODE_CHG_MAIN, 35000, 0, 2000, 2000, 32767, 0,
                                  32'hFFFF_FFFF));
    sample_queue.push_back(sample(MODE_CHG_MAIN, 35000, 0, 2000, 2000, 32767, 0, 32'd119998));
    sample_queue.push_back(sample(MODE_CHG_MAIN, 35000, 0, 2000, 2000, -32768, 0, 32'd119999));
    sample_queue.push_back(sample(MODE_CHG_SYM, 65535, 29, -32768, 32767, 0, 32767, 32'd0));
    sample_queue.push_back(sample(MODE_CHG_SYM, 0, 28, 32767, -32768, 0, 32767, 32'd0));
    sample_queue.push_back(sample(MODE_SPARE_HI, 0, -32768, -32768, 32767, 32767, 32767,
                                  32'hFFFF_FFFF));
    sample_queue.push_back(sample(MODE_SPARE_LO, 65535, 32767, 32767, -32768, -32768, -32768,
                                  32'd0));
    sample_queue.push_back(sample(MODE_IDLE, 65535, -32768, -32768, 32767, 32767, 32767,
                                  32'hFFFF_FFFF));
  endtask

  task automatic write_limit(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic program_limits(input cfg_t c);
    write_limit(REG_VOLT_LOW, c.voltage_low_limit);
    write_limit(REG_DRV_VOLT_HIGH, c.drive_voltage_high_limit);
    write_limit(REG_CHG_VOLT_HIGH, c.charge_voltage_high_limit);
    write_limit(REG_CHG_CUR, c.charge_current_limit);
    write_limit(REG_DSG_CUR, c.discharge_current_limit);
    write_limit(REG_CHG_TEMP_HIGH, c.charge_temp_high_limit);
    write_limit(REG_DRV_TEMP_HIGH, c.drive_temp_high_limit);
    write_limit(REG_FULL_CAP, c.full_capacity_limit);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limits = c;
    settings_used++;
  endtask

  task automatic wait_idle();
    while (sample_queue.size() != 0 || in_valid_i || flags_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        flags_due.push_back(update_limit_flags(in_data_i));
        mode_hits[in_data_i.mode]++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_data_i  <= sample_queue.pop_front();
          in_valid_i <= 1'b1;
          send_gap = pick_gap(send_burst);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (flags_due.size() == 0) begin
          report_mismatch($sformatf("flag result %b with no sample pending", out_data_o));
        end else begin
          want = flags_due.pop_front();
          for (int b = 8; b >= 0; b--) begin
            if (out_data_o[b] !== want[b])
              report_mismatch($sformatf("result %0d: %s is %b, expected %b", results_seen,
                                        flag_names[b], out_data_o[b], want[b]));
          end
          if (want.full_flag) full_seen++;
        end
        results_seen++;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_stall = pick_gap(recv_burst);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    queue_directed();
    queue_random(350);
    wait_idle();
    program_limits(LIMITS_MIN);
    queue_random(300);
    wait_idle();
    program_limits(LIMITS_MAX);
    queue_random(300);
    wait_idle();
    program_limits(cfg_t'({$urandom, $urandom, $urandom, $urandom}));
    queue_random(300);
    wait_idle();
    program_limits(cfg_t'({$urandom, $urandom, $urandom, $urandom}));
    queue_random(300);
    wait_idle();
    program_limits(LIMITS_DEFAULT);
    queue_random(300);
    wait_idle();
    if (flags_due.size() != 0)
      report_mismatch($sformatf("%0d flag results never arrived", flags_due.size()));
    $display("%0d samples under %0d limit settings: drive %0d, supervise %0d, main %0d, sym %0d",
             results_seen, settings_used, mode_hits[MODE_DRIVE], mode_hits[MODE_CHG_SUP],
             mode_hits[MODE_CHG_MAIN], mode_hits[MODE_CHG_SYM]);
    $display("idle or spare mode samples %0d, results with full set %0d, mismatches %0d",
             results_seen - mode_hits[MODE_DRIVE] - mode_hits[MODE_CHG_SUP]
             - mode_hits[MODE_CHG_MAIN] - mode_hits[MODE_CHG_SYM], full_seen, mismatches);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout: %0d flag results still due", flags_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: battery_limit_monitor_top.f
hw/rtl/blm_pkg.sv
hw/rtl/blm_cfg_regs.sv
hw/rtl/blm_core.sv
hw/rtl/battery_limit_monitor_top.sv
bench/battery_limit_monitor_top_tb.sv
